### src/dda_line_rasterizer_row_bounds_macros.svh
// Assertion helpers for the line rasterizer.
// Both sample on the rising clock and are disabled while reset is high.
`ifndef DDA_LINE_RASTERIZER_ROW_BOUNDS_MACROS_SVH
`define DDA_LINE_RASTERIZER_ROW_BOUNDS_MACROS_SVH

// pre holds in a cycle -> post holds in the same cycle
`define DDARB_ASSERT_IMPLY(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("rasterizer assertion failed");

// pre holds in a cycle -> post holds in the next cycle
`define DDARB_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("rasterizer assertion failed");

`endif

### src/ddarb_pkg.sv
`timescale 1ns / 1ps

package ddarb_pkg;

   // request commands
   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STEP  = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   // configuration register indexes
   localparam logic CSR_VISIBLE_WIDTH  = 1'b0;
   localparam logic CSR_VISIBLE_HEIGHT = 1'b1;

   localparam logic [11:0] VISIBLE_WIDTH_RESET  = 12'd640;
   localparam logic [11:0] VISIBLE_HEIGHT_RESET = 12'd480;

   // an empty row: min at or above any x, max at or below any x
   localparam logic [15:0] ROW_EMPTY_MIN = 16'h7fff;
   localparam logic [15:0] ROW_EMPTY_MAX = 16'h8000;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] x_start;
      logic signed [15:0] y_start;
      logic signed [15:0] x_end;
      logic signed [15:0] y_end;
      logic [31:0]        line_color;
      logic [10:0]        query_row;
   } req_type;

   typedef struct packed {
      logic               write_enable;
      logic signed [15:0] pixel_x;
      logic signed [15:0] pixel_y;
      logic [31:0]        pixel_color;
      logic               last_pixel;
      logic signed [15:0] row_low_x;
      logic signed [15:0] row_high_x;
   } rsp_type;

endpackage

### src/dda_line_rasterizer_row_bounds.sv
`timescale 1ns / 1ps
// DDA line rasterizer with per-row x bounds. A start request latches the start point and
// color and runs a radix-2 divider that forms both 16.16 increments in parallel, one
// quotient bit per cycle: the block takes no request while the divider runs. Step and read
// requests are taken one per clock while the output does not stall; each step on an active
// line returns one pixel, and each read of a stored row returns and clears its bounds. A
// result goes through the memory access stage and the response register. The row bounds
// live in one single-port-write, single-port-read memory (min and max packed in one word)
// that is read on acceptance and written back as the request leaves the memory access
// stage; a request to the row just written gets the new value by forwarding. After reset
// the block clears that memory, one row per cycle, and takes no request until it is done;
// configuration writes are taken at any time.

module dda_line_rasterizer_row_bounds #(
   parameter int MAX_ROWS = 2048
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ddarb_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ddarb_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [11:0]        csr_wdata
);

`include "dda_line_rasterizer_row_bounds_macros.svh"

   localparam int ROW_AW = $clog2(MAX_ROWS);
   localparam logic [16:0] ROW_LIMIT = 17'(MAX_ROWS);
   localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(MAX_ROWS - 1);

   // configuration
   logic [11:0] width_ff;
   logic [11:0] height_ff;

   // clearing pass
   logic              clearing_ff;
   logic [ROW_AW-1:0] clr_addr_ff;

   // line state
   logic               line_active_ff;
   logic [31:0]        x_acc_ff;
   logic [31:0]        y_acc_ff;
   logic signed [17:0] x_inc_ff;
   logic signed [17:0] y_inc_ff;
   logic [15:0]        steps_rem_ff;
   logic [31:0]        color_ff;

   // divider
   logic        div_busy_ff;
   logic [4:0]  div_cnt_ff;
   logic [15:0] div_steps_ff;
   logic [31:0] x_num_ff, x_num_in;
   logic [31:0] y_num_ff, y_num_in;
   logic [15:0] x_rem_ff, x_rem_in;
   logic [15:0] y_rem_ff, y_rem_in;
   logic        x_neg_ff, y_neg_ff;

   // memory access stage
   logic               s1_valid_ff;
   logic               s1_read_ff;
   logic               s1_upd_ff;
   logic               s1_we_ff;
   logic               s1_last_ff;
   logic signed [15:0] s1_px_ff;
   logic signed [15:0] s1_py_ff;
   logic [31:0]        s1_color_ff;
   logic [ROW_AW-1:0]  s1_addr_ff;
   logic               s1_fwd_ff;
   logic [31:0]        s1_fwd_data_ff;
   logic [31:0]        rd_data_ff;

   // response register
   logic               rsp_valid_ff;
   ddarb_pkg::rsp_type rsp_data_ff;

   // row memory: {min, max}
   logic [31:0] row_mem [MAX_ROWS];

   // ---------------------------------------------------------------
   // request decode
   logic req_fire;
   logic is_start, is_step, is_read;
   logic s1_retire;

   assign s1_retire = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clearing_ff && !div_busy_ff && (!s1_valid_ff || s1_retire);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      is_start = 1'b0;
      is_step  = 1'b0;
      is_read  = 1'b0;
      case (req_data.cmd)
         ddarb_pkg::CMD_START: is_start = 1'b1;
         ddarb_pkg::CMD_STEP:  is_step  = 1'b1;
         ddarb_pkg::CMD_READ:  is_read  = 1'b1;
         default: ;
      endcase
   end

   // start: deltas, step count, dividend magnitudes
   logic signed [16:0] dx, dy;
   logic [16:0]        ax, ay;
   logic [15:0]        steps_max;
   logic [15:0]        steps_new;

   always_comb begin
      dx = {req_data.x_end[15], req_data.x_end} - {req_data.x_start[15], req_data.x_start};
      dy = {req_data.y_end[15], req_data.y_end} - {req_data.y_start[15], req_data.y_start};
      ax = dx[16] ? 17'(-dx) : 17'(dx);
      ay = dy[16] ? 17'(-dy) : 17'(dy);
      steps_max = (ax > ay) ? ax[15:0] : ay[15:0];
      steps_new = (steps_max == 16'd0) ? 16'd1 : steps_max;
   end

   // step: current pixel and its row
   logic signed [15:0] cur_px, cur_py;
   logic               row_vis, pix_we;
   logic [15:0]        row_idx;
   logic               row_in_store;
   logic [ROW_AW-1:0]  req_addr;

   always_comb begin
      cur_px  = x_acc_ff[31:16];
      cur_py  = y_acc_ff[31:16];
      row_vis = !cur_py[15] && (16'(cur_py) < {4'd0, height_ff});
      pix_we  = row_vis && !cur_px[15] && (16'(cur_px) < {4'd0, width_ff});
      row_idx = is_read ? {5'd0, req_data.query_row} : 16'(cur_py);
      row_in_store = {1'b0, row_idx} < ROW_LIMIT;
      req_addr = row_idx[ROW_AW-1:0];
   end

   // ---------------------------------------------------------------
   // divider iteration, x and y lanes share the divisor
   logic [16:0] x_trial, y_trial;
   logic        x_ge, y_ge;
   logic [16:0] x_diff, y_diff;

   always_comb begin
      x_trial  = {x_rem_ff, x_num_ff[31]};
      y_trial  = {y_rem_ff, y_num_ff[31]};
      x_ge     = x_trial >= {1'b0, div_steps_ff};
      y_ge     = y_trial >= {1'b0, div_steps_ff};
      x_diff   = x_trial - {1'b0, div_steps_ff};
      y_diff   = y_trial - {1'b0, div_steps_ff};
      x_rem_in = x_ge ? x_diff[15:0] : x_trial[15:0];
      y_rem_in = y_ge ? y_diff[15:0] : y_trial[15:0];
      x_num_in = {x_num_ff[30:0], x_ge};
      y_num_in = {y_num_ff[30:0], y_ge};
   end

   // quotient is at most 65536, so 17 bits carry it
   logic signed [17:0] x_quot, y_quot;
   assign x_quot = {1'b0, x_num_in[16:0]};
   assign y_quot = {1'b0, y_num_in[16:0]};

   // ---------------------------------------------------------------
   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ddarb_pkg::VISIBLE_WIDTH_RESET;
         height_ff <= ddarb_pkg::VISIBLE_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ddarb_pkg::CSR_VISIBLE_WIDTH:  width_ff  <= csr_wdata;
            ddarb_pkg::CSR_VISIBLE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clearing pass over the row memory
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == ROW_LAST) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // line state and divider control
   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
         x_acc_ff       <= '0;
         y_acc_ff       <= '0;
         x_inc_ff       <= '0;
         y_inc_ff       <= '0;
         steps_rem_ff   <= '0;
         color_ff       <= '0;
         div_busy_ff    <= 1'b0;
         div_cnt_ff     <= '0;
      end else begin
         if (req_fire && is_start) begin
            line_active_ff <= 1'b0;
            x_acc_ff       <= {req_data.x_start, 16'd0};
            y_acc_ff       <= {req_data.y_start, 16'd0};
            steps_rem_ff   <= steps_new;
            color_ff       <= req_data.line_color;
            div_busy_ff    <= 1'b1;
            div_cnt_ff     <= 5'd31;
         end else if (req_fire && is_step && line_active_ff) begin
            x_acc_ff <= x_acc_ff + 32'(x_inc_ff);
            y_acc_ff <= y_acc_ff + 32'(y_inc_ff);
            if (steps_rem_ff <= 16'd1) begin
               steps_rem_ff   <= '0;
               line_active_ff <= 1'b0;
            end else begin
               steps_rem_ff <= steps_rem_ff - 16'd1;
            end
         end
         if (div_busy_ff) begin
            div_cnt_ff <= div_cnt_ff - 5'd1;
            if (div_cnt_ff == 5'd0) begin
               div_busy_ff    <= 1'b0;
               line_active_ff <= 1'b1;
               x_inc_ff       <= x_neg_ff ? -x_quot : x_quot;
               y_inc_ff       <= y_neg_ff ? -y_quot : y_quot;
            end
         end
      end
   end

   // divider datapath
   always_ff @(posedge clock) begin
      if (req_fire && is_start) begin
         div_steps_ff <= steps_new;
         x_num_ff     <= {ax[15:0], 16'd0};
         y_num_ff     <= {ay[15:0], 16'd0};
         x_rem_ff     <= '0;
         y_rem_ff     <= '0;
         x_neg_ff     <= dx[16];
         y_neg_ff     <= dy[16];
      end else if (div_busy_ff) begin
         x_num_ff <= x_num_in;
         y_num_ff <= y_num_in;
         x_rem_ff <= x_rem_in;
         y_rem_ff <= y_rem_in;
      end
   end

   // ---------------------------------------------------------------
   // read-modify-write of the row bounds
   logic [31:0]        old_bounds;
   logic signed [15:0] old_min, old_max;
   logic signed [15:0] new_min, new_max;
   logic               mem_we;
   logic [ROW_AW-1:0]  mem_waddr;
   logic [31:0]        mem_wdata;
   logic [31:0]        s1_wdata;

   always_comb begin
      old_bounds = s1_fwd_ff ? s1_fwd_data_ff : rd_data_ff;
      old_min    = old_bounds[31:16];
      old_max    = old_bounds[15:0];
      new_min    = (s1_px_ff < old_min) ? s1_px_ff : old_min;
      new_max    = (s1_px_ff > old_max) ? s1_px_ff : old_max;
      if (s1_read_ff) begin
         s1_wdata = {ddarb_pkg::ROW_EMPTY_MIN, ddarb_pkg::ROW_EMPTY_MAX};
      end else begin
         s1_wdata = {new_min, new_max};
      end
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = {ddarb_pkg::ROW_EMPTY_MIN, ddarb_pkg::ROW_EMPTY_MAX};
      end else begin
         mem_we    = s1_retire && s1_upd_ff;
         mem_waddr = s1_addr_ff;
         mem_wdata = s1_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_waddr] <= mem_wdata;
      end
      if (req_fire) begin
         rd_data_ff <= row_mem[req_addr];
      end
   end

   // stage that holds a request while its row is read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= is_read || (is_step && line_active_ff);
      end else if (s1_retire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_read_ff     <= is_read;
         s1_upd_ff      <= is_read ? row_in_store : (row_vis && row_in_store);
         s1_we_ff       <= pix_we;
         s1_last_ff     <= steps_rem_ff <= 16'd1;
         s1_px_ff       <= cur_px;
         s1_py_ff       <= cur_py;
         s1_color_ff    <= color_ff;
         s1_addr_ff     <= req_addr;
         // the row written at this edge is not yet in the read data
         s1_fwd_ff      <= s1_retire && s1_upd_ff && (s1_addr_ff == req_addr);
         s1_fwd_data_ff <= s1_wdata;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_retire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_retire) begin
         if (s1_read_ff) begin
            rsp_data_ff.write_enable <= 1'b0;
            rsp_data_ff.pixel_x      <= '0;
            rsp_data_ff.pixel_y      <= '0;
            rsp_data_ff.pixel_color  <= '0;
            rsp_data_ff.last_pixel   <= 1'b0;
            if (s1_upd_ff) begin
               rsp_data_ff.row_low_x  <= old_min;
               rsp_data_ff.row_high_x <= old_max;
            end else begin
               rsp_data_ff.row_low_x  <= ddarb_pkg::ROW_EMPTY_MIN;
               rsp_data_ff.row_high_x <= ddarb_pkg::ROW_EMPTY_MAX;
            end
         end else begin
            rsp_data_ff.write_enable <= s1_we_ff;
            rsp_data_ff.pixel_x      <= s1_px_ff;
            rsp_data_ff.pixel_y      <= s1_py_ff;
            rsp_data_ff.pixel_color  <= s1_color_ff;
            rsp_data_ff.last_pixel   <= s1_last_ff;
            rsp_data_ff.row_low_x    <= '0;
            rsp_data_ff.row_high_x   <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------
   // checks
   `DDARB_ASSERT_IMPLY(a_clear_no_pending, clearing_ff, !s1_valid_ff && !div_busy_ff)
   `DDARB_ASSERT_NEXT(a_stage_drains, s1_valid_ff && !rsp_valid_ff, rsp_valid_ff)
   `DDARB_ASSERT_IMPLY(a_active_has_steps, line_active_ff, steps_rem_ff != 16'd0)
   `DDARB_ASSERT_IMPLY(a_div_done_active, $fell(div_busy_ff), line_active_ff)

endmodule

### verif/dda_line_rasterizer_row_bounds_tb.sv
`timescale 1ns / 1ps

module dda_line_rasterizer_row_bounds_tb;

   localparam int ROW_DEPTH = 2048;
   // start division plus the memory access stage and response register, with margin
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SEGMENT_ITEMS = 80;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   ddarb_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   ddarb_pkg::rsp_type rsp_data;
   logic               csr_we = 1'b0;
   logic               csr_index = ddarb_pkg::CSR_VISIBLE_WIDTH;
   logic [11:0]        csr_wdata = '0;

   dda_line_rasterizer_row_bounds #(.MAX_ROWS(ROW_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the rasterizer state
   logic [11:0]        vis_w;
   logic [11:0]        vis_h;
   logic               line_on;
   logic [31:0]        acc_x;
   logic [31:0]        acc_y;
   logic [31:0]        inc_x;
   logic [31:0]        inc_y;
   logic [15:0]        steps_left;
   logic [31:0]        color_held;
   logic signed [15:0] row_lo [ROW_DEPTH];
   logic signed [15:0] row_hi [ROW_DEPTH];

   ddarb_pkg::req_type cmd_backlog[$];
   ddarb_pkg::rsp_type owed_results[$];
   ddarb_pkg::rsp_type oldest_owed;
   int                 send_idle_pct;
   int                 recv_stall_pct;
   int                 mismatches = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // 16.16 increment, truncated toward zero
   function automatic int fixed_increment(int d, int steps);
      longint num;
      num = longint'(d) * 65536;
      return int'(num / steps);
   endfunction

   // advance the shadow state by one accepted request, queue what it returns
   function automatic void trace_request(ddarb_pkg::req_type r);
      int                 dx;
      int                 dy;
      int                 ax;
      int                 ay;
      int                 steps;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic               row_vis;
      ddarb_pkg::rsp_type res;
      res = '0;
      case (r.cmd)
         ddarb_pkg::CMD_START: begin
            dx = int'(r.x_end) - int'(r.x_start);
            dy = int'(r.y_end) - int'(r.y_start);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            steps = (ax > ay) ? ax : ay;
            if (steps == 0) steps = 1;
            inc_x = fixed_increment(dx, steps);
            inc_y = fixed_increment(dy, steps);
            acc_x = {r.x_start, 16'h0000};
            acc_y = {r.y_start, 16'h0000};
            steps_left = steps[15:0];
            color_held = r.line_color;
            line_on = 1'b1;
         end
         ddarb_pkg::CMD_STEP: begin
            if (line_on) begin
               px = acc_x[31:16];
               py = acc_y[31:16];
               row_vis = (py >= 0) && (int'(py) < int'(vis_h));
               res.write_enable = row_vis && (px >= 0) && (int'(px) < int'(vis_w));
               // rows past the store depth are visible but not recorded
               if (row_vis && int'(py) < ROW_DEPTH) begin
                  if (px > row_hi[py[10:0]]) row_hi[py[10:0]] = px;
                  if (px < row_lo[py[10:0]]) row_lo[py[10:0]] = px;
               end
               res.pixel_x = px;
               res.pixel_y = py;
               res.pixel_color = color_held;
               res.last_pixel = (steps_left <= 16'd1);
               owed_results.push_back(res);
               acc_x = acc_x + inc_x;
               acc_y = acc_y + inc_y;
               if (steps_left <= 16'd1) begin
                  steps_left = '0;
                  line_on = 1'b0;
               end else begin
                  steps_left = steps_left - 16'd1;
               end
            end
         end
         ddarb_pkg::CMD_READ: begin
            res.row_low_x = ddarb_pkg::ROW_EMPTY_MIN;
            res.row_high_x = ddarb_pkg::ROW_EMPTY_MAX;
            if (int'(r.query_row) < ROW_DEPTH) begin
               res.row_low_x = row_lo[r.query_row];
               res.row_high_x = row_hi[r.query_row];
               row_lo[r.query_row] = ddarb_pkg::ROW_EMPTY_MIN;
               row_hi[r.query_row] = ddarb_pkg::ROW_EMPTY_MAX;
            end
            owed_results.push_back(res);
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // request driver: holds each request until taken, idles at random between them
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) trace_request(req_data);
         if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= cmd_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor: random backpressure, in-order compare
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               $error("result arrived with nothing outstanding");
               mismatches++;
            end else begin
               oldest_owed = owed_results.pop_front();
               compare_field("write_enable", oldest_owed.write_enable, rsp_data.write_enable);
               compare_field("pixel_x", oldest_owed.pixel_x, rsp_data.pixel_x);
               compare_field("pixel_y", oldest_owed.pixel_y, rsp_data.pixel_y);
               compare_field("pixel_color", oldest_owed.pixel_color, rsp_data.pixel_color);
               compare_field("last_pixel", oldest_owed.last_pixel, rsp_data.last_pixel);
               compare_field("row_low_x", oldest_owed.row_low_x, rsp_data.row_low_x);
               compare_field("row_high_x", oldest_owed.row_high_x, rsp_data.row_high_x);
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // request builders: fields a command does not use carry random bits
   function automatic ddarb_pkg::req_type noise_request();
      logic [127:0] bits;
      bits = {$urandom, $urandom, $urandom, $urandom};
      return bits[$bits(ddarb_pkg::req_type)-1:0];
   endfunction

   function automatic void queue_start(int x0, int y0, int x1, int y1, logic [31:0] color);
      ddarb_pkg::req_type r;
      r = noise_request();
      r.cmd = ddarb_pkg::CMD_START;
      r.x_start = x0[15:0];
      r.y_start = y0[15:0];
      r.x_end = x1[15:0];
      r.y_end = y1[15:0];
      r.line_color = color;
      cmd_backlog.push_back(r);
   endfunction

   function automatic void queue_step();
      ddarb_pkg::req_type r;
      r = noise_request();
      r.cmd = ddarb_pkg::CMD_STEP;
      cmd_backlog.push_back(r);
   endfunction

   function automatic void queue_read(int row);
      ddarb_pkg::req_type r;
      r = noise_request();
      r.cmd = ddarb_pkg::CMD_READ;
      r.query_row = row[10:0];
      cmd_backlog.push_back(r);
   endfunction

   function automatic void queue_unused();
      ddarb_pkg::req_type r;
      r = noise_request();
      r.cmd = CMD_UNUSED;
      cmd_backlog.push_back(r);
   endfunction

   // coordinate mostly near the surface, sometimes at the store edge or the 16-bit limits
   function automatic int pick_coord(int extent);
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return int'($urandom_range(extent + 16)) - 8;
         5:             return 2044 + int'($urandom_range(8));
         6:             return extent - 4 + int'($urandom_range(8));
         7:             return int'($urandom_range(65535)) - 32768;
         8:             return $urandom_range(1) ? 32767 : -32768;
         default:       return int'($urandom_range(8)) - 4;
      endcase
   endfunction

   // mostly whole lines followed by reads of their rows; some noise
   task automatic queue_segment(int n_items);
      int queued;
      int kind;
      int x0;
      int y0;
      int x1;
      int y1;
      int span;
      int n_steps;
      int lo;
      int hi;
      int n_reads;
      queued = 0;
      while (queued < n_items) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            x0 = pick_coord(int'(vis_w));
            y0 = pick_coord(int'(vis_h));
            span = ($urandom_range(9) == 0) ? 300 : 24;
            x1 = x0 + int'($urandom_range(2 * span)) - span;
            y1 = y0 + int'($urandom_range(2 * span)) - span;
            queue_start(x0, y0, x1, y1, $urandom);
            n_steps = (x1 > x0) ? x1 - x0 : x0 - x1;
            if (((y1 > y0) ? y1 - y0 : y0 - y1) > n_steps)
               n_steps = (y1 > y0) ? y1 - y0 : y0 - y1;
            if (n_steps == 0) n_steps = 1;
            if (n_steps > 64) begin
               n_steps = $urandom_range(64, 1);
            end else if ($urandom_range(9) == 0) begin
               n_steps = n_steps + 1;
            end else if ($urandom_range(4) == 0) begin
               n_steps = $urandom_range(n_steps, 1);
            end
            repeat (n_steps) queue_step();
            lo = (y0 < y1) ? y0 : y1;
            hi = (y0 < y1) ? y1 : y0;
            if (hi - lo > 64) hi = lo + 64;
            n_reads = $urandom_range(3, 1);
            repeat (n_reads) queue_read((lo + int'($urandom_range(hi - lo))) & 2047);
            queued += 1 + n_steps + n_reads;
         end else if (kind < 85) begin
            queue_read($urandom_range(2047));
            queued++;
         end else if (kind < 95) begin
            queue_start(pick_coord(int'(vis_w)), pick_coord(int'(vis_h)),
                        int'($urandom_range(65535)) - 32768,
                        int'($urandom_range(65535)) - 32768, $urandom);
            n_steps = $urandom_range(4);
            repeat (n_steps) queue_step();
            queued += 1 + n_steps;
         end else begin
            queue_unused();
         end
      end
   endtask

   // wait until every request is taken and answered, then let a division finish
   task automatic drain();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || req_valid || owed_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_visibility(logic [11:0] width, logic [11:0] height);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= ddarb_pkg::CSR_VISIBLE_WIDTH;
      csr_wdata <= width;
      vis_w = width;
      @(posedge clock);
      csr_index <= ddarb_pkg::CSR_VISIBLE_HEIGHT;
      csr_wdata <= height;
      vis_h = height;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // run limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("dda_line_rasterizer_row_bounds: mismatch");
      $finish;
   end

   // stimulus sequence
   initial begin
      vis_w = ddarb_pkg::VISIBLE_WIDTH_RESET;
      vis_h = ddarb_pkg::VISIBLE_HEIGHT_RESET;
      line_on = 1'b0;
      acc_x = '0;
      acc_y = '0;
      inc_x = '0;
      inc_y = '0;
      steps_left = '0;
      color_held = '0;
      for (int i = 0; i < ROW_DEPTH; i++) begin
         row_lo[i] = ddarb_pkg::ROW_EMPTY_MIN;
         row_hi[i] = ddarb_pkg::ROW_EMPTY_MAX;
      end
      send_idle_pct = 6;
      recv_stall_pct = 77;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: narrow surface, visible rows beyond the store depth
      set_visibility(12'd40, 12'd2100);
      queue_read(0);
      queue_step();
      queue_unused();
      queue_start(0, 0, 0, 0, 32'hffff_ffff);
      queue_step();
      queue_step();
      queue_start(-3, 2, 45, 5, 32'ha5a5_5a5a);
      repeat (3) queue_step();
      queue_start(5, 2046, 7, 2051, 32'h1234_5678);
      repeat (5) queue_step();
      queue_read(2047);
      queue_read(2047);
      queue_read(2);
      queue_start(32767, -32768, -32768, 32767, 32'h0000_0000);
      repeat (2) queue_step();
      // a new start drops the line in progress
      queue_start(10, 3, 10, -3, 32'h0f0f_f0f0);
      queue_step();
      queue_read(3);
      drain();

      // nothing visible
      set_visibility(12'd0, 12'd0);
      queue_segment(SEGMENT_ITEMS);
      drain();

      set_visibility(12'd4095, 12'd4095);
      queue_segment(SEGMENT_ITEMS);
      drain();

      send_idle_pct = 77;
      recv_stall_pct = 6;
      set_visibility(12'd640, 12'd480);
      queue_segment(SEGMENT_ITEMS);
      drain();

      set_visibility(12'd1, 12'd1);
      queue_segment(SEGMENT_ITEMS);
      drain();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      set_visibility(12'd2048, 12'd2048);
      queue_segment(SEGMENT_ITEMS);
      drain();

      if (mismatches == 0 && owed_results.size() == 0) begin
         $display("dda_line_rasterizer_row_bounds: match");
      end else begin
         $display("dda_line_rasterizer_row_bounds: mismatch");
      end
      $finish;
   end

endmodule

### files.f
+incdir+src
src/ddarb_pkg.sv
src/dda_line_rasterizer_row_bounds.sv
verif/dda_line_rasterizer_row_bounds_tb.sv
